// File: design/abpw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// abpw_pkg: shared types and constants of the alpha blend pixel writer
// Lane layout of the pipelined divider and the side data that travels with it.
// ---------------------------------------------------------------------------
package abpw_pkg;

  localparam int COORD_BITS = 16;
  localparam int REG_W      = 13;
  localparam int CMP_W      = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;

  // Dividend 2*num+den stays below 2^25; one spare bit.
  localparam int NUM_W      = 26;
  localparam int Q_W        = 9;
  localparam int STEPS      = 3;
  localparam int DIV_STAGES = Q_W / STEPS;
  localparam int LANES      = 4;
  localparam int LANE_A     = 3;

  localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(640);
  localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(480);

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MODE_DROP,
    MODE_COPY,
    MODE_BLEND,
    MODE_BLACK
  } mode_e;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] dsh;
    logic [Q_W-1:0]   quot;
  } lane_t;

  typedef struct packed {
    mode_e          mode;
    logic [2:0][7:0] color;
  } side_t;

endpackage

// File: design/abpw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abpw_front: clip, products and divider setup
// Two register stages: 8x8 products, then numerators and blend denominator.
// ---------------------------------------------------------------------------
module abpw_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic [abpw_pkg::COORD_BITS-1:0]   pos_x_i,
  input  wire logic [abpw_pkg::COORD_BITS-1:0]   pos_y_i,
  input  wire logic [2:0][7:0]                   src_i,
  input  wire logic [7:0]                        src_alpha_i,
  input  wire logic [2:0][7:0]                   dst_i,
  input  wire logic [7:0]                        dst_alpha_i,
  input  wire logic [abpw_pkg::REG_W-1:0]        width_i,
  input  wire logic [abpw_pkg::REG_W-1:0]        height_i,
  output logic                                   valid_o,
  output abpw_pkg::lane_t [abpw_pkg::LANES-1:0]  lanes_o,
  output abpw_pkg::side_t                        side_o
);
  import abpw_pkg::*;

  logic               va_q;
  mode_e              mode_a_d, mode_a_q;
  logic [2:0][7:0]    src_a_q;
  logic [2:0][15:0]   ssa_d, ssa_q, dda_d, dda_q;
  logic [7:0]         sa_a_q, da_a_q, inv_a_q;
  logic [CMP_W-1:0]   x_ext, y_ext;
  logic               clip;

  logic [16:0]        den;
  logic [NUM_W-1:0]   num [3];
  logic               vb_q;
  lane_t [LANES-1:0]  lanes_d, lanes_q;
  side_t              side_d, side_q;

  assign x_ext = CMP_W'(pos_x_i);
  assign y_ext = CMP_W'(pos_y_i);
  assign clip  = pos_x_i[COORD_BITS-1] || pos_y_i[COORD_BITS-1] ||
                 (x_ext >= CMP_W'(width_i)) || (y_ext >= CMP_W'(height_i));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ssa_d[i] = 16'(src_i[i]) * 16'(src_alpha_i);
      dda_d[i] = 16'(dst_i[i]) * 16'(dst_alpha_i);
    end
    if (clip || src_alpha_i == 8'd0) begin
      mode_a_d = MODE_DROP;
    end else if (src_alpha_i == 8'd255) begin
      mode_a_d = MODE_COPY;
    end else begin
      mode_a_d = MODE_BLEND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_a_q <= mode_a_d;
    src_a_q  <= src_i;
    ssa_q    <= ssa_d;
    dda_q    <= dda_d;
    sa_a_q   <= src_alpha_i;
    da_a_q   <= dst_alpha_i;
    inv_a_q  <= 8'd255 - src_alpha_i;
  end

  // den = sa*255 + da*(255-sa); times 255 as shift and subtract.
  // Divisors enter shifted up by the quotient width (nine bits).
  always_comb begin
    den = ({1'b0, sa_a_q, 8'b0} - 17'(sa_a_q)) + 17'(16'(da_a_q) * 16'(inv_a_q));
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'({ssa_q[i], 8'b0} - 24'(ssa_q[i])) +
               NUM_W'(24'(dda_q[i]) * 24'(inv_a_q));
      lanes_d[i].rem  = (num[i] << 1) + NUM_W'(den);
      lanes_d[i].dsh  = NUM_W'(den) << (Q_W + 1);
      lanes_d[i].quot = '0;
    end
    lanes_d[LANE_A].rem  = (NUM_W'(den) << 1) + NUM_W'(255);
    lanes_d[LANE_A].dsh  = NUM_W'(510) << Q_W;
    lanes_d[LANE_A].quot = '0;
    side_d.color = src_a_q;
    side_d.mode  = (mode_a_q == MODE_BLEND && den == 17'd0) ? MODE_BLACK : mode_a_q;
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    side_q  <= side_d;
  end

  assign valid_o = vb_q;
  assign lanes_o = lanes_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// File: design/abpw_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// abpw_div_stage: one stage of the restoring divider
// Resolves three quotient bits on every lane, then registers.
// ---------------------------------------------------------------------------
module abpw_div_stage (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  abpw_pkg::lane_t [abpw_pkg::LANES-1:0]  lanes_i,
  input  abpw_pkg::side_t                        side_i,
  output logic                                   valid_o,
  output abpw_pkg::lane_t [abpw_pkg::LANES-1:0]  lanes_o,
  output abpw_pkg::side_t                        side_o
);
  import abpw_pkg::*;

  logic               valid_q;
  lane_t [LANES-1:0]  lanes_d, lanes_q;
  side_t              side_q;

  // Divisor enters pre-shifted; halve it before each step.
  always_comb begin
    lanes_d = lanes_i;
    for (int l = 0; l < LANES; l++) begin
      for (int s = 0; s < STEPS; s++) begin
        lanes_d[l].dsh = lanes_d[l].dsh >> 1;
        if (lanes_d[l].rem >= lanes_d[l].dsh) begin
          lanes_d[l].rem  = lanes_d[l].rem - lanes_d[l].dsh;
          lanes_d[l].quot = {lanes_d[l].quot[Q_W-2:0], 1'b1};
        end else begin
          lanes_d[l].quot = {lanes_d[l].quot[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    side_q  <= side_i;
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;
  assign side_o  = side_q;

endmodule
`default_nettype wire

// File: design/alpha_blend_pixel_write.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// alpha_blend_pixel_write: clipped source-over RGBA8 pixel blend
// Six-stage pipeline, one request per clock, one result per request.
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  request  | start_i, busy_o (always 0) | pos_x/y, src_*, dst_*
//  result   | done_o strobe, one cycle   | write_enable, out_*
//  config   | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// Six register stages: two front stages (products, then numerators and
// denominator), three divider stages of three quotient bits each, and the
// output register. A new request is taken in every cycle; the pipeline never
// stalls since the receiver takes each result as it appears. Reset clears
// the valid bits and loads frame size 640 x 480.
// ---------------------------------------------------------------------------
module alpha_blend_pixel_write (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [abpw_pkg::COORD_BITS-1:0]  pos_x_i,
  input  wire logic [abpw_pkg::COORD_BITS-1:0]  pos_y_i,
  input  wire logic [7:0]                       src_red_i,
  input  wire logic [7:0]                       src_green_i,
  input  wire logic [7:0]                       src_blue_i,
  input  wire logic [7:0]                       src_alpha_i,
  input  wire logic [7:0]                       dst_red_i,
  input  wire logic [7:0]                       dst_green_i,
  input  wire logic [7:0]                       dst_blue_i,
  input  wire logic [7:0]                       dst_alpha_i,
  output logic                                  done_o,
  output logic                                  write_enable_o,
  output logic [7:0]                            out_red_o,
  output logic [7:0]                            out_green_o,
  output logic [7:0]                            out_blue_o,
  output logic [7:0]                            out_alpha_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             cfg_index_i,
  input  wire logic [abpw_pkg::REG_W-1:0]       cfg_data_i
);
  import abpw_pkg::*;

  logic [REG_W-1:0]   width_q, height_q;
  logic               accept;

  logic               vld  [DIV_STAGES+1];
  lane_t [LANES-1:0]  lanes [DIV_STAGES+1];
  side_t              side  [DIV_STAGES+1];

  logic [3:0][7:0]    quot8;
  logic               done_q, we_d, we_q;
  logic [3:0][7:0]    pix_d, pix_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  // Frame size registers; only two indexes exist.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  abpw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .src_i       ({src_blue_i, src_green_i, src_red_i}),
    .src_alpha_i (src_alpha_i),
    .dst_i       ({dst_blue_i, dst_green_i, dst_red_i}),
    .dst_alpha_i (dst_alpha_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .valid_o     (vld[0]),
    .lanes_o     (lanes[0]),
    .side_o      (side[0])
  );

  // Divider: each stage resolves three quotient bits on all four lanes.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    abpw_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .lanes_i (lanes[g]),
      .side_i  (side[g]),
      .valid_o (vld[g+1]),
      .lanes_o (lanes[g+1]),
      .side_o  (side[g+1])
    );
  end

  // Saturate quotients and pick the result by mode.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quot8[l] = lanes[DIV_STAGES][l].quot[Q_W-1] ? 8'd255
                                                 : lanes[DIV_STAGES][l].quot[7:0];
    end
    case (side[DIV_STAGES].mode)
      MODE_COPY: begin
        we_d  = 1'b1;
        pix_d = {8'd255, side[DIV_STAGES].color};
      end
      MODE_BLEND: begin
        we_d  = 1'b1;
        pix_d = quot8;
      end
      MODE_BLACK: begin
        we_d  = 1'b1;
        pix_d = '0;
      end
      default: begin
        we_d  = 1'b0;
        pix_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    we_q  <= we_d;
    pix_q <= pix_d;
  end

  assign done_o         = done_q;
  assign write_enable_o = we_q;
  assign out_red_o      = pix_q[0];
  assign out_green_o    = pix_q[1];
  assign out_blue_o     = pix_q[2];
  assign out_alpha_o    = pix_q[LANE_A];

  // Every accepted request leaves the pipe as a done strobe.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("request lost in pipeline");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 6))
    else $error("result without request");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !write_enable_o) |->
      (out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0 &&
       out_alpha_o == 8'd0))
    else $error("dropped pixel carries color");

  a_alpha_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_enable_o && out_alpha_o == 8'd0) |->
      (out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0))
    else $error("transparent write with color");

endmodule
`default_nettype wire

// File: verif/alpha_blend_pixel_write_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alpha_blend_pixel_write_checker: blend predictor and result scoreboard
// Watches requests, register writes and result strobes, computes the expected
// pixel per request and compares each result with the oldest one in order.
// ---------------------------------------------------------------------------
module alpha_blend_pixel_write_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  logic [abpw_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic [abpw_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic [7:0]                      src_red_i,
  input  logic [7:0]                      src_green_i,
  input  logic [7:0]                      src_blue_i,
  input  logic [7:0]                      src_alpha_i,
  input  logic [7:0]                      dst_red_i,
  input  logic [7:0]                      dst_green_i,
  input  logic [7:0]                      dst_blue_i,
  input  logic [7:0]                      dst_alpha_i,
  input  logic                            done_i,
  input  logic                            write_enable_i,
  input  logic [7:0]                      out_red_i,
  input  logic [7:0]                      out_green_i,
  input  logic [7:0]                      out_blue_i,
  input  logic [7:0]                      out_alpha_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic                            cfg_index_i,
  input  logic [abpw_pkg::REG_W-1:0]      cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import abpw_pkg::*;

  typedef struct packed {
    logic       we;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  logic [REG_W-1:0] width_q, height_q;
  pixel_t           pixel_queue[$];

  function automatic logic [7:0] round_div(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic pixel_t blend_pixel(
      logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
      logic [7:0] sr, logic [7:0] sg, logic [7:0] sb, logic [7:0] sa,
      logic [7:0] dr, logic [7:0] dg, logic [7:0] db, logic [7:0] da);
    pixel_t          p;
    longint unsigned den;
    longint          xs, ys;
    p  = '0;
    xs = x;
    ys = y;
    if (xs < 0 || ys < 0 || xs >= longint'(width_q) || ys >= longint'(height_q)) return p;
    if (sa == 0) return p;
    p.we = 1'b1;
    if (sa == 8'd255) begin
      p.r = sr; p.g = sg; p.b = sb; p.a = 8'd255;
      return p;
    end
    den = sa * 255 + da * (255 - sa);
    if (den == 0) return p;
    p.r = round_div(sr * sa * 255 + dr * da * (255 - sa), den);
    p.g = round_div(sg * sa * 255 + dg * da * (255 - sa), den);
    p.b = round_div(sb * sa * 255 + db * da * (255 - sa), den);
    p.a = round_div(den, 255);
    return p;
  endfunction

  assign pending_o = pixel_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      width_q      <= WIDTH_RST;
      height_q     <= HEIGHT_RST;
      fail_count_o <= 0;
      pixel_queue.delete();
    end else begin
      // Compare first: a result never belongs to a request taken this edge.
      if (done_i) begin
        got = '{write_enable_i, out_red_i, out_green_i, out_blue_i, out_alpha_i};
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pixel_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected we=%b rgba=%h_%h_%h_%h actual we=%b rgba=%h_%h_%h_%h",
                     $time, want.we, want.r, want.g, want.b, want.a,
                     got.we, got.r, got.g, got.b, got.a);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        pixel_queue.push_back(blend_pixel(pos_x_i, pos_y_i, src_red_i, src_green_i,
                                          src_blue_i, src_alpha_i, dst_red_i, dst_green_i,
                                          dst_blue_i, dst_alpha_i));
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_FRAME_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
      end
    end
  end
endmodule

// File: verif/alpha_blend_pixel_write_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alpha_blend_pixel_write_tb: stimulus and verdict for the pixel blender
// Runs phases of frame sizes (reset, extremes, zero, random); each phase
// sends directed corner pixels then random ones, with random request gaps.
// ---------------------------------------------------------------------------
module alpha_blend_pixel_write_tb;
  import abpw_pkg::*;

  localparam int LATENCY     = 6;
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [COORD_BITS-1:0] pos_x_i = '0, pos_y_i = '0;
  logic [7:0]            src_red_i = '0, src_green_i = '0, src_blue_i = '0, src_alpha_i = '0;
  logic [7:0]            dst_red_i = '0, dst_green_i = '0, dst_blue_i = '0, dst_alpha_i = '0;
  logic                  done_o, write_enable_o;
  logic [7:0]            out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic                  cfg_index_i = CFG_FRAME_WIDTH;
  logic [REG_W-1:0]      cfg_data_i = '0;
  int                    fail_count, pending;
  int                    cycle_count = 0;
  logic [REG_W-1:0]      cur_width = WIDTH_RST, cur_height = HEIGHT_RST;
  bit                    no_gaps = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  alpha_blend_pixel_write uut (.*);

  alpha_blend_pixel_write_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .pos_x_i, .pos_y_i,
    .src_red_i, .src_green_i, .src_blue_i, .src_alpha_i,
    .dst_red_i, .dst_green_i, .dst_blue_i, .dst_alpha_i,
    .done_i(done_o), .write_enable_i(write_enable_o), .out_red_i(out_red_o),
    .out_green_i(out_green_o), .out_blue_i(out_blue_o), .out_alpha_i(out_alpha_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending));

  // Watchdog: end the run if anything hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("alpha_blend_pixel_write test failed");
      $finish;
    end
  end

  // Random idle gaps unless gapless, then hold one request until the block takes it.
  task automatic send_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                            logic [31:0] src, logic [31:0] dst);
    while (!no_gaps && $urandom_range(99) < 35) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    {src_red_i, src_green_i, src_blue_i, src_alpha_i} <= src;
    {dst_red_i, dst_green_i, dst_blue_i, dst_alpha_i} <= dst;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Drop valid for one cycle after each write so back-to-back calls stay clean.
  task automatic write_reg(logic idx, logic [REG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) cur_width = val;
    else cur_height = val;
    @(posedge clk_i);
  endtask

  // Coordinates: mostly inside the frame, some near edges, some anywhere.
  function automatic logic [COORD_BITS-1:0] pick_coord(logic [REG_W-1:0] lim);
    int k;
    k = $urandom_range(9);
    if (k < 6 && lim > 0) return COORD_BITS'($urandom_range(lim - 1));
    if (k < 8) return COORD_BITS'(int'(lim) + $urandom_range(2) - 1);
    return COORD_BITS'($urandom);
  endfunction

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(3));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_phase(int count);
    logic [REG_W-1:0] w, h;
    w = cur_width;
    h = cur_height;
    // Corners, clip edges, invisible, opaque, zero dest alpha, extremes.
    send_pixel(16'd0, 16'd0, 32'hFFFFFFFF, 32'h00000000);
    send_pixel(COORD_BITS'(w) - 16'd1, COORD_BITS'(h) - 16'd1, 32'h12345680, 32'hABCDEF7F);
    send_pixel(COORD_BITS'(w), 16'd0, 32'h11223380, 32'h445566FF);
    send_pixel(16'd0, COORD_BITS'(h), 32'h11223380, 32'h445566FF);
    send_pixel(16'hFFFF, 16'd0, 32'h11223380, 32'h445566FF);
    send_pixel(16'd0, 16'h8000, 32'h11223380, 32'h445566FF);
    send_pixel(16'h7FFF, 16'h7FFF, 32'hFFFFFF01, 32'hFFFFFFFF);
    send_pixel(16'd1, 16'd1, 32'hFFFFFF00, 32'h00000000);
    send_pixel(16'd1, 16'd0, 32'hFFFFFF01, 32'h00000000);
    send_pixel(16'd0, 16'd1, 32'h000000FE, 32'hFFFFFFFF);
    send_pixel(16'd0, 16'd0, 32'hFFFFFFFE, 32'h000000FF);
    send_pixel(16'd0, 16'd0, 32'h00000001, 32'hFFFFFF01);
    send_pixel(16'd0, 16'd0, 32'h80808080, 32'h7F7F7F80);
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 3 && i < count / 3 + 60);
      send_pixel(pick_coord(w), pick_coord(h),
                 {8'($urandom), 8'($urandom), 8'($urandom), pick_alpha()},
                 {8'($urandom), 8'($urandom), 8'($urandom), pick_alpha()});
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_phase(150);
    write_reg(CFG_FRAME_WIDTH, 13'd4096);
    write_reg(CFG_FRAME_HEIGHT, 13'd4096);
    run_phase(150);
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    run_phase(100);
    write_reg(CFG_FRAME_WIDTH, 13'd0);
    write_reg(CFG_FRAME_HEIGHT, 13'd8191);
    run_phase(50);
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'd0);
    run_phase(50);
    write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(4096, 1)));
    write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(4096, 1)));
    run_phase(150);
    if (fail_count == 0) begin
      $display("alpha_blend_pixel_write test passed");
    end else begin
      $display("alpha_blend_pixel_write test failed");
    end
    $finish;
  end
endmodule

// File: sim.f
design/abpw_pkg.sv
design/abpw_front.sv
design/abpw_div_stage.sv
design/alpha_blend_pixel_write.sv
verif/alpha_blend_pixel_write_checker.sv
verif/alpha_blend_pixel_write_tb.sv
